/* rtl/lrps_pkg.sv */
// ----------------------------------------------------------------------------
// LED request priority select package
// Shared types, codes and constants for the LED request priority select block.
// ----------------------------------------------------------------------------
package lrps_pkg;

   // Default number of virtual LED slots
   localparam int SLOTS_DEFAULT = 3;

   // Flash mode codes of a request
   localparam logic [1:0] FLASH_NONE  = 2'd0;
   localparam logic [1:0] FLASH_TIMED = 2'd1;
   localparam logic [1:0] FLASH_HW    = 2'd2;
   localparam logic [1:0] FLASH_BAD   = 2'd3;

   // Color handling
   localparam logic [23:0] WHITE_IN  = 24'hffffff;
   localparam logic [23:0] WHITE_OUT = 24'h80ff80;
   localparam logic [4:0]  MID_LEVEL = 5'd31;

   // Slope scaling: 450/1000 = 9/20 and 50/1000 = 1/20.
   // x/20 is taken as (x * ceil(2^24/20)) >> 24, exact for x below 2^20.
   localparam int          RECIP_SHIFT = 24;
   localparam int          MUL_IN_W    = 20;
   localparam int          MUL_PROD_W  = 40;
   localparam logic [19:0] RECIP_20    = 20'd838861;

   // Drive mode of a slot and of a result
   typedef enum logic [1:0] {
      MODE_OFF    = 2'd0,
      MODE_STEADY = 2'd1,
      MODE_SLOPE  = 2'd2
   } mode_type;

   // Sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_WRITE,
      ST_SCAN,
      ST_MUL_SHORT,
      ST_MUL_LONG,
      ST_EMIT
   } state_type;

   // One stored slot request
   typedef struct packed {
      mode_type    mode;
      logic [23:0] color;
      logic [15:0] on_time;
      logic [15:0] off_time;
   } slot_entry_type;

   // Input item
   typedef struct packed {
      logic [1:0]  led_slot;
      logic [23:0] color;
      logic [1:0]  flash_mode;
      logic [15:0] flash_on_ms;
      logic [15:0] flash_off_ms;
   } req_type;

   // Result item
   typedef struct packed {
      logic [1:0]  drive_mode;
      logic [23:0] drive_color;
      logic [14:0] rise_first;
      logic [11:0] rise_second;
      logic [11:0] fall_first;
      logic [14:0] fall_second;
      logic [4:0]  mid_level;
      logic [15:0] dark_time;
      logic        drive_valid;
      logic        error;
   } rsp_type;

endpackage

/* rtl/lrps_slot_file.sv */
// ----------------------------------------------------------------------------
// LED request slot file
// Holds one request per slot; one write port and one read port for the scan.
// ----------------------------------------------------------------------------
module lrps_slot_file #(
   parameter int SLOTS = lrps_pkg::SLOTS_DEFAULT,
   localparam int IDX_W = $clog2(SLOTS)
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     wr_en,
   input  logic [IDX_W-1:0]         wr_idx,
   input  lrps_pkg::slot_entry_type wr_entry,
   input  logic [IDX_W-1:0]         rd_idx,
   output lrps_pkg::slot_entry_type rd_entry
);

   lrps_pkg::slot_entry_type entry_ff [SLOTS];

   // Clear every slot to off at reset, replace one slot per write
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < SLOTS; i++) begin
            entry_ff[i] <= '0;
         end
      end else if (wr_en) begin
         entry_ff[wr_idx] <= wr_entry;
      end
   end

   // Read the slot under scan
   assign rd_entry = entry_ff[rd_idx];

endmodule

/* rtl/lrps_recip_mul.sv */
// ----------------------------------------------------------------------------
// Shared divide-by-twenty unit
// Reciprocal multiply with a registered quotient, used once per slope time.
// ----------------------------------------------------------------------------
module lrps_recip_mul (
   input  logic                          clock,
   input  logic [lrps_pkg::MUL_IN_W-1:0] op,
   output logic [15:0]                   quot
);

   logic [lrps_pkg::MUL_PROD_W-1:0] prod;
   logic [15:0]                     quot_ff;
   logic [15:0]                     quot_in;

   // Multiply by the reciprocal of twenty and keep the integer part
   assign prod    = lrps_pkg::MUL_PROD_W'(op) * lrps_pkg::MUL_PROD_W'(lrps_pkg::RECIP_20);
   assign quot_in = prod[lrps_pkg::RECIP_SHIFT +: 16];

   always_ff @(posedge clock) begin
      quot_ff <= quot_in;
   end

   assign quot = quot_ff;

endmodule

/* rtl/led_request_priority_select.sv */
// ----------------------------------------------------------------------------
// LED request priority select
// Stores per-slot LED requests and issues the drive setting of the winner.
// ----------------------------------------------------------------------------
// Each request item on the req_ channel rewrites one slot (attention,
// notification, charging) and produces exactly one result item on the rsp_
// channel: the drive setting of the lowest-numbered slot that is lit, or of
// the last slot when all are off, or an error item for a bad slot, or for a
// bad flash mode with a nonzero color. Both channels use valid/ready.
// A result waits on the slot scan, which reads one slot per cycle and stops
// at the winning slot, and on the two slope times, which go one after the
// other through a single multiplier; error items skip both. The block takes
// no new item until the current result has reached the output register.
// The finished result sits in an output register, so req_ready returns while
// it waits; a stalled receiver holds the next result in the final sequencer
// step until the register frees.
// Reset (synchronous, active high) turns every slot off and empties the
// output register.
// ----------------------------------------------------------------------------
module led_request_priority_select #(
   parameter int SLOTS = lrps_pkg::SLOTS_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  lrps_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output lrps_pkg::rsp_type rsp_data
);

   localparam int               IDX_W = $clog2(SLOTS);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);
   localparam logic [IDX_W+1:0] SLOT_LIMIT = (IDX_W + 2)'(SLOTS);

   lrps_pkg::state_type      state_ff, state_in;
   lrps_pkg::req_type        req_ff;
   lrps_pkg::slot_entry_type pick_ff, pick_in;
   lrps_pkg::slot_entry_type wr_entry, rd_entry;
   lrps_pkg::rsp_type        rsp_ff, rsp_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic                     err_ff, err_in;
   logic [IDX_W-1:0]         scan_idx_ff, scan_idx_in;
   logic [11:0]              short_ff, short_in;
   logic [IDX_W+1:0]         slot_wide;
   logic [IDX_W-1:0]         wr_idx;
   logic                     wr_en;
   logic                     rsp_load;
   logic [23:0]              eff_color;
   logic [lrps_pkg::MUL_IN_W-1:0] mul_op;
   logic [lrps_pkg::MUL_IN_W-1:0] on_wide;
   logic [15:0]              quot;

   // Slot index of the held request at the scan width
   assign slot_wide = (IDX_W + 2)'(req_ff.led_slot);
   assign wr_idx    = slot_wide[IDX_W-1:0];
   assign on_wide   = lrps_pkg::MUL_IN_W'(pick_ff.on_time);

   lrps_slot_file #(
      .SLOTS (SLOTS)
   ) u_slot_file (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (wr_en),
      .wr_idx   (wr_idx),
      .wr_entry (wr_entry),
      .rd_idx   (scan_idx_ff),
      .rd_entry (rd_entry)
   );

   lrps_recip_mul u_recip_mul (
      .clock (clock),
      .op    (mul_op),
      .quot  (quot)
   );

   // Sequencer state and control
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= lrps_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         req_ff <= req_data;
      end
      err_ff      <= err_in;
      scan_idx_ff <= scan_idx_in;
      pick_ff     <= pick_in;
      short_ff    <= short_in;
      if (rsp_load) begin
         rsp_ff <= rsp_in;
      end
   end

   // Next state, slot update and result assembly
   always_comb begin
      state_in     = state_ff;
      err_in       = err_ff;
      scan_idx_in  = scan_idx_ff;
      pick_in      = pick_ff;
      short_in     = short_ff;
      req_ready    = 1'b0;
      wr_en        = 1'b0;
      wr_entry     = '0;
      mul_op       = '0;
      rsp_load     = 1'b0;
      rsp_in       = '0;
      eff_color    = req_ff.color;
      if (req_ff.led_slot == 2'd0 && req_ff.flash_mode == lrps_pkg::FLASH_NONE) begin
         eff_color = '0;
      end

      unique case (state_ff)
         lrps_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               state_in = lrps_pkg::ST_WRITE;
            end
         end
         lrps_pkg::ST_WRITE: begin
            // Rewrite the addressed slot; a bad mode leaves it cleared
            err_in = 1'b0;
            if (slot_wide >= SLOT_LIMIT) begin
               err_in = 1'b1;
            end else begin
               wr_en = 1'b1;
               if (eff_color != '0) begin
                  wr_entry.color = (eff_color == lrps_pkg::WHITE_IN) ?
                                   lrps_pkg::WHITE_OUT : eff_color;
                  priority if (req_ff.flash_mode == lrps_pkg::FLASH_NONE) begin
                     wr_entry.mode = lrps_pkg::MODE_STEADY;
                  end else if (req_ff.flash_mode == lrps_pkg::FLASH_TIMED ||
                               req_ff.flash_mode == lrps_pkg::FLASH_HW) begin
                     wr_entry.mode     = lrps_pkg::MODE_SLOPE;
                     wr_entry.on_time  = req_ff.flash_on_ms;
                     wr_entry.off_time = req_ff.flash_off_ms;
                  end else begin
                     wr_entry = '0;
                     err_in   = 1'b1;
                  end
               end
            end
            scan_idx_in = '0;
            state_in    = err_in ? lrps_pkg::ST_EMIT : lrps_pkg::ST_SCAN;
         end
         lrps_pkg::ST_SCAN: begin
            // Stop at the first lit slot, or at the last slot
            if (rd_entry.mode != lrps_pkg::MODE_OFF || scan_idx_ff == LAST_IDX) begin
               pick_in  = rd_entry;
               state_in = lrps_pkg::ST_MUL_SHORT;
            end else begin
               scan_idx_in = scan_idx_ff + 1'b1;
            end
         end
         lrps_pkg::ST_MUL_SHORT: begin
            // on / 20
            mul_op   = on_wide;
            state_in = lrps_pkg::ST_MUL_LONG;
         end
         lrps_pkg::ST_MUL_LONG: begin
            // 9 * on / 20, and capture the short slope time
            mul_op   = (on_wide << 3) + on_wide;
            short_in = quot[11:0];
            state_in = lrps_pkg::ST_EMIT;
         end
         lrps_pkg::ST_EMIT: begin
            // Keep the long slope time on the multiplier while the result waits
            mul_op = (on_wide << 3) + on_wide;
            // Hand the result to the output register once it is free
            if (err_ff) begin
               rsp_in.error = 1'b1;
            end else begin
               rsp_in.drive_mode  = pick_ff.mode;
               rsp_in.drive_color = pick_ff.color;
               rsp_in.rise_first  = quot[14:0];
               rsp_in.rise_second = short_ff;
               rsp_in.fall_first  = short_ff;
               rsp_in.fall_second = quot[14:0];
               rsp_in.mid_level   = (pick_ff.mode == lrps_pkg::MODE_SLOPE) ?
                                    lrps_pkg::MID_LEVEL : '0;
               rsp_in.dark_time   = pick_ff.off_time;
               rsp_in.drive_valid = 1'b1;
            end
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_load = 1'b1;
               state_in = lrps_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = lrps_pkg::ST_IDLE;
         end
      endcase
   end

   // Output register occupancy
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // An item never carries both a drive setting and an error
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_data.drive_valid && rsp_data.error))
      else $error("result carries both drive_valid and error");

   // Mid level follows slope mode on every drive setting
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.drive_valid) |->
      ((rsp_data.mid_level == lrps_pkg::MID_LEVEL) ==
       (rsp_data.drive_mode == lrps_pkg::MODE_SLOPE)))
      else $error("mid level does not match drive mode");

   // An accepted item starts the slot update next cycle
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff == lrps_pkg::ST_WRITE))
      else $error("accepted item did not start the slot update");

   // A result is loaded only into a free or draining output register
   assert property (@(posedge clock) disable iff (reset)
      rsp_load |-> (!rsp_valid_ff || rsp_ready))
      else $error("result overwrote a pending item");

endmodule

/* tb/sv/led_request_priority_select_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// LED request priority select testbench
// Sends directed and random LED requests through the req_ channel, predicts
// the drive setting for every accepted item from a private copy of the slot
// table, and compares each rsp_ item field by field in arrival order. Both
// sides idle at random; the receiver also holds off once for a long stretch
// so that the block backs up and stalls its input.
// ----------------------------------------------------------------------------
import lrps_pkg::*;

// Slope scaling in parts per thousand
localparam int unsigned SLOPE_LONG_PM  = 450;
localparam int unsigned SLOPE_HALF_PM  = 500;
localparam int unsigned SLOPE_SHORT_PM = SLOPE_HALF_PM - SLOPE_LONG_PM;
localparam int unsigned SLOPE_SCALE_PM = 1000;

class led_drive_scoreboard;
   mode_type    slot_mode     [SLOTS_DEFAULT];
   logic [23:0] slot_color    [SLOTS_DEFAULT];
   logic [15:0] slot_on_time  [SLOTS_DEFAULT];
   logic [15:0] slot_off_time [SLOTS_DEFAULT];
   rsp_type     drive_queue [$];
   int unsigned mismatches;
   int unsigned results_seen;

   function new();
      mismatches   = 0;
      results_seen = 0;
      for (int s = 0; s < SLOTS_DEFAULT; s++) begin
         clear_slot(s);
      end
   endfunction

   function void clear_slot(int s);
      slot_mode[s]     = MODE_OFF;
      slot_color[s]    = '0;
      slot_on_time[s]  = '0;
      slot_off_time[s] = '0;
   endfunction

   // Update the slot table for one request and work out the drive setting
   function rsp_type predict_drive(req_type item);
      rsp_type     r;
      logic [23:0] col;
      int          s;
      int          pick;
      bit          found;
      int unsigned on;
      r = '0;
      if (item.led_slot >= SLOTS_DEFAULT) begin
         r.error = 1'b1;
         return r;
      end
      s   = item.led_slot;
      col = item.color;
      // attention slot has no steady light
      if (s == 0 && item.flash_mode == FLASH_NONE) begin
         col = '0;
      end
      clear_slot(s);
      if (col != '0) begin
         if (col == WHITE_IN) begin
            col = WHITE_OUT;
         end
         case (item.flash_mode)
            FLASH_NONE: begin
               slot_mode[s]  = MODE_STEADY;
               slot_color[s] = col;
            end
            FLASH_TIMED, FLASH_HW: begin
               slot_mode[s]     = MODE_SLOPE;
               slot_color[s]    = col;
               slot_on_time[s]  = item.flash_on_ms;
               slot_off_time[s] = item.flash_off_ms;
            end
            default: begin
               r.error = 1'b1;
               return r;
            end
         endcase
      end
      // lowest lit slot wins, else the last slot
      pick  = SLOTS_DEFAULT - 1;
      found = 1'b0;
      for (int k = 0; k < SLOTS_DEFAULT; k++) begin
         if (!found && slot_mode[k] != MODE_OFF) begin
            pick  = k;
            found = 1'b1;
         end
      end
      on            = slot_on_time[pick];
      r.drive_mode  = slot_mode[pick];
      r.drive_color = slot_color[pick];
      r.rise_first  = 15'((SLOPE_LONG_PM * on) / SLOPE_SCALE_PM);
      r.rise_second = 12'((SLOPE_SHORT_PM * on) / SLOPE_SCALE_PM);
      r.fall_first  = 12'((SLOPE_SHORT_PM * on) / SLOPE_SCALE_PM);
      r.fall_second = 15'((SLOPE_LONG_PM * on) / SLOPE_SCALE_PM);
      r.mid_level   = (slot_mode[pick] == MODE_SLOPE) ? MID_LEVEL : 5'd0;
      r.dark_time   = slot_off_time[pick];
      r.drive_valid = 1'b1;
      return r;
   endfunction

   function void note_request(req_type item);
      drive_queue.push_back(predict_drive(item));
   endfunction

   task report(string msg);
      $display("ERROR at %0t: %s", $time, msg);
      mismatches++;
   endtask

   task compare_field(string name, logic [31:0] got_value, logic [31:0] want_value);
      if (got_value !== want_value) begin
         report($sformatf("result %0d field %s got 0x%0h want 0x%0h",
                          results_seen, name, got_value, want_value));
      end
   endtask

   task check_result(rsp_type got);
      rsp_type want;
      if (drive_queue.size() == 0) begin
         report($sformatf("result %0d arrived with no request pending", results_seen));
      end else begin
         want = drive_queue.pop_front();
         compare_field("drive_mode",  got.drive_mode,  want.drive_mode);
         compare_field("drive_color", got.drive_color, want.drive_color);
         compare_field("rise_first",  got.rise_first,  want.rise_first);
         compare_field("rise_second", got.rise_second, want.rise_second);
         compare_field("fall_first",  got.fall_first,  want.fall_first);
         compare_field("fall_second", got.fall_second, want.fall_second);
         compare_field("mid_level",   got.mid_level,   want.mid_level);
         compare_field("dark_time",   got.dark_time,   want.dark_time);
         compare_field("drive_valid", got.drive_valid, want.drive_valid);
         compare_field("error",       got.error,       want.error);
      end
      results_seen++;
   endtask
endclass

module led_request_priority_select_tb;

   localparam int HALF_PERIOD  = 6;
   localparam int RESET_CYCLES = 9;
   localparam int RANDOM_ITEMS = 800;
   localparam int IDLE_PERCENT = 7;
   localparam int QUIET_FIRST  = 300;
   localparam int QUIET_LAST   = 499;
   localparam int HOLD_AFTER   = 650;
   localparam int HOLD_CYCLES  = 300;
   localparam int DRAIN_CYCLES = 40;
   localparam int STALL_LIMIT  = 3000;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   bit          quiet        = 1'b0;
   int unsigned stall_cycles = 0;

   led_drive_scoreboard sb = new();

   always #(HALF_PERIOD) clock = ~clock;

   led_request_priority_select i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   // Predict on each accepted request, check each accepted result
   always @(posedge clock) begin
      if (reset) begin
         stall_cycles <= 0;
      end else begin
         if (req_valid && req_ready) begin
            sb.note_request(req_data);
         end
         if (rsp_valid && rsp_ready) begin
            sb.check_result(rsp_data);
         end
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
            stall_cycles <= 0;
         end else begin
            stall_cycles <= stall_cycles + 1;
         end
      end
   end

   // Drop the run when nothing moves for too long
   initial begin
      while (stall_cycles < STALL_LIMIT) begin
         @(posedge clock);
      end
      $display("Mismatches found");
      $finish;
   end

   function automatic req_type make_request(logic [1:0] slot, logic [23:0] color,
                                            logic [1:0] mode, logic [15:0] on_ms,
                                            logic [15:0] off_ms);
      req_type item;
      item.led_slot     = slot;
      item.color        = color;
      item.flash_mode   = mode;
      item.flash_on_ms  = on_ms;
      item.flash_off_ms = off_ms;
      return item;
   endfunction

   // Mostly valid slots and modes, with some zero, white and extreme values
   function automatic req_type random_request();
      req_type     item;
      int unsigned pick;
      pick = $urandom_range(99);
      item.led_slot = (pick < 8) ? 2'd3 : 2'($urandom_range(SLOTS_DEFAULT - 1));
      pick = $urandom_range(99);
      if (pick < 30) begin
         item.flash_mode = FLASH_NONE;
      end else if (pick < 60) begin
         item.flash_mode = FLASH_TIMED;
      end else if (pick < 90) begin
         item.flash_mode = FLASH_HW;
      end else begin
         item.flash_mode = FLASH_BAD;
      end
      pick = $urandom_range(99);
      if (pick < 15) begin
         item.color = '0;
      end else if (pick < 23) begin
         item.color = WHITE_IN;
      end else if (pick < 28) begin
         item.color = 24'($urandom_range(255, 1));
      end else begin
         item.color = 24'($urandom);
      end
      pick = $urandom_range(99);
      item.flash_on_ms = (pick < 10) ? 16'h0000 : (pick < 20) ? 16'hffff : 16'($urandom);
      pick = $urandom_range(99);
      item.flash_off_ms = (pick < 10) ? 16'h0000 : (pick < 20) ? 16'hffff : 16'($urandom);
      return item;
   endfunction

   // Offer one item after an optional random gap, hold it until accepted
   task send_request(req_type item);
      while (!quiet && $urandom_range(99) < IDLE_PERCENT) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      @(posedge clock);
      while (!req_ready) begin
         @(posedge clock);
      end
   endtask

   // Receiver: random idling, one long hold-off once traffic is flowing
   initial begin
      int unsigned taken;
      bit          held;
      taken = 0;
      held  = 1'b0;
      while (reset) begin
         @(posedge clock);
      end
      forever begin
         if (!held && taken >= HOLD_AFTER) begin
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            held = 1'b1;
         end else begin
            rsp_ready <= quiet || ($urandom_range(99) >= IDLE_PERCENT);
            @(posedge clock);
            if (rsp_valid && rsp_ready) begin
               taken++;
            end
         end
      end
   end

   // Sender: reset, directed items, random items, then drain
   initial begin
      int unsigned n;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // attention steady turns the slot off, so every slot is off
      send_request(make_request(2'd0, 24'hff0000, FLASH_NONE, 16'd100, 16'd100));
      send_request(make_request(2'd2, 24'h123456, FLASH_NONE, 16'hffff, 16'hffff));
      send_request(make_request(2'd1, WHITE_IN, FLASH_TIMED, 16'hffff, 16'hffff));
      send_request(make_request(2'd0, 24'h0000ff, FLASH_HW, 16'd0, 16'd0));
      send_request(make_request(2'd0, WHITE_IN, FLASH_TIMED, 16'd1000, 16'd1));
      // attention steady with a higher-numbered slot still lit
      send_request(make_request(2'd0, WHITE_IN, FLASH_NONE, 16'd5, 16'd5));
      // invalid slot
      send_request(make_request(2'd3, 24'hffffff, FLASH_TIMED, 16'hffff, 16'hffff));
      // invalid flash mode clears the slot and reports an error
      send_request(make_request(2'd1, 24'h00ff00, FLASH_BAD, 16'd300, 16'd400));
      // invalid flash mode with zero color just clears the slot
      send_request(make_request(2'd0, 24'h000000, FLASH_BAD, 16'd300, 16'd400));
      // zero color turns the last lit slot off
      send_request(make_request(2'd2, 24'h000000, FLASH_TIMED, 16'd50, 16'd60));
      send_request(make_request(2'd2, WHITE_IN, FLASH_NONE, 16'hffff, 16'hffff));
      send_request(make_request(2'd1, 24'h000001, FLASH_HW, 16'd19, 16'haaaa));
      send_request(make_request(2'd1, 24'hfffffe, FLASH_TIMED, 16'd20, 16'h5555));
      send_request(make_request(2'd1, 24'h800000, FLASH_HW, 16'hfffe, 16'h0001));
      send_request(make_request(2'd3, 24'h000000, FLASH_BAD, 16'h0000, 16'h0000));
      send_request(make_request(2'd1, 24'h000000, FLASH_NONE, 16'd7, 16'd7));
      send_request(make_request(2'd0, 24'h5a5a5a, FLASH_HW, 16'h8000, 16'h8000));
      send_request(make_request(2'd2, 24'h800000, FLASH_BAD, 16'd1, 16'd1));
      send_request(make_request(2'd0, 24'h000000, FLASH_TIMED, 16'd9, 16'd9));
      send_request(make_request(2'd2, 24'ha5a5a5, FLASH_TIMED, 16'h7fff, 16'hffff));

      for (n = 0; n < RANDOM_ITEMS; n++) begin
         quiet = (n >= QUIET_FIRST && n <= QUIET_LAST);
         send_request(random_request());
      end
      quiet = 1'b0;
      req_valid <= 1'b0;

      // wait out every expected result, then a few more cycles
      while (sb.drive_queue.size() != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (sb.mismatches == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
